/* hw/rtl/ggw_pkg.sv */
// ----------------------------------------------------------------------------
// ggw_pkg: shared types and constants of the greedy grid walker
// Widths, register indexes, result codes and the neighbour step function.
// ----------------------------------------------------------------------------
`default_nettype none

package ggw_pkg;

   localparam int CoordW    = 6;
   localparam int CostW     = 14;
   localparam int CellAddrW = 2 * CoordW;
   localparam int Cells     = 1 << CellAddrW;
   localparam int CountW    = CellAddrW + 1;
   localparam int MemW      = CostW + 1;     // visited mark above the cost
   localparam int CsrIndexW = 3;

   localparam int GridSide  = 64;
   localparam int MaxSide   = 1 << CoordW;
   localparam int Side      = (GridSide < MaxSide) ? GridSide : MaxSide;
   localparam logic [CoordW:0] SideLim = (CoordW + 1)'(Side);

   localparam logic [CostW-1:0]  Uncarved       = CostW'(10000);
   localparam logic [CostW-1:0]  WallLimitReset = CostW'(1000);
   localparam logic [CoordW-1:0] StartReset     = CoordW'(2);
   localparam logic [CoordW-1:0] GoalReset      = CoordW'(48);

   localparam logic KindLoad = 1'b0;
   localparam logic KindStep = 1'b1;

   typedef enum logic [CsrIndexW-1:0] {
      REG_START_X    = 3'd0,
      REG_START_Y    = 3'd1,
      REG_GOAL_X     = 3'd2,
      REG_GOAL_Y     = 3'd3,
      REG_WALL_LIMIT = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_LOADED = 2'd0,
      ST_MOVED  = 2'd1,
      ST_BACK   = 2'd2,
      ST_NOPATH = 2'd3
   } status_type;

   typedef struct packed {
      logic [CoordW-1:0] start_x;
      logic [CoordW-1:0] start_y;
      logic [CoordW-1:0] goal_x;
      logic [CoordW-1:0] goal_y;
      logic [CostW-1:0]  wall_limit;
   } cfg_type;

   typedef struct packed {
      logic              set_x;
      logic              set_y;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
   } pos_set_type;

   typedef struct packed {
      logic              kind;
      logic [CoordW-1:0] cell_x;
      logic [CoordW-1:0] cell_y;
      logic [CostW-1:0]  cell_cost;
   } item_type;

   typedef struct packed {
      logic [CoordW-1:0] pos_x;
      logic [CoordW-1:0] pos_y;
      status_type        status;
      logic              goal_near;
   } result_type;

   typedef struct packed {
      logic              ok;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
   } nb_type;

   // Neighbour in direction 0..3 = x+1, y+1, x-1, y-1, with an inside-grid flag.
   // A step below zero wraps to all ones and so fails the side compare.
   function automatic nb_type nb_coord(input logic [CoordW-1:0] x,
                                       input logic [CoordW-1:0] y,
                                       input logic [1:0] dir);
      logic [CoordW:0] nx;
      logic [CoordW:0] ny;
      nb_type r;
      nx = {1'b0, x};
      ny = {1'b0, y};
      case (dir)
         2'd0: nx = {1'b0, x} + (CoordW + 1)'(1);
         2'd1: ny = {1'b0, y} + (CoordW + 1)'(1);
         2'd2: nx = {1'b0, x} - (CoordW + 1)'(1);
         default: ny = {1'b0, y} - (CoordW + 1)'(1);
      endcase
      r.ok = (nx < SideLim) && (ny < SideLim);
      r.x  = nx[CoordW-1:0];
      r.y  = ny[CoordW-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ggw_ram.sv */
// ----------------------------------------------------------------------------
// ggw_ram: generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ggw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hw/rtl/ggw_engine.sv */
// ----------------------------------------------------------------------------
// ggw_engine: walk sequencer around the cell memory and the path stack
// Clears the visited marks after reset, then serves loads and walk steps
// by read-modify-write on the cell memory and push/pop on the stack memory.
// ----------------------------------------------------------------------------
`default_nettype none

module ggw_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ggw_pkg::cfg_type    cfg,
   input  wire ggw_pkg::pos_set_type pos_set,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire ggw_pkg::item_type   in_item,
   output logic                     res_valid,
   input  wire logic                res_ready,
   output ggw_pkg::result_type      res
);

   import ggw_pkg::*;

   typedef enum logic [7:0] {
      S_CLEAR   = 8'b0000_0001,
      S_IDLE    = 8'b0000_0010,
      S_LOAD_RD = 8'b0000_0100,
      S_LOAD_WR = 8'b0000_1000,
      S_SCAN    = 8'b0001_0000,
      S_DECIDE  = 8'b0010_0000,
      S_POP     = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [CoordW-1:0]     cur_x_ff, cur_x_in;
   logic [CoordW-1:0]     cur_y_ff, cur_y_in;
   logic [CountW-1:0]     count_ff, count_in;
   logic [CellAddrW-1:0]  clr_ff, clr_in;
   item_type              item_ff, item_in;
   logic                  near_ff, near_in;
   logic [2:0]            scan_ff, scan_in;
   logic                  pend_ok_ff, pend_ok_in;
   logic [1:0]            pend_dir_ff, pend_dir_in;
   logic                  best_found_ff, best_found_in;
   logic [1:0]            best_dir_ff, best_dir_in;
   logic [CostW-1:0]      best_cost_ff, best_cost_in;
   status_type            status_ff, status_in;

   logic                  cell_we;
   logic [CellAddrW-1:0]  cell_waddr, cell_raddr;
   logic [MemW-1:0]       cell_wdata, cell_rdata;
   logic                  stk_we;
   logic [CellAddrW-1:0]  stk_waddr, stk_raddr;
   logic [CellAddrW-1:0]  stk_wdata, stk_rdata;

   logic [CountW-1:0]     count_m1;
   nb_type                scan_nb, best_nb;
   logic                  cand_ok;
   logic                  load_in_grid;
   logic [CoordW:0]       cx, cy, gx, gy;
   logic                  x_eq, y_eq, x_adj, y_adj, near_calc;

   ggw_ram #(.WIDTH(MemW), .DEPTH(Cells)) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .raddr (cell_raddr),
      .rdata (cell_rdata)
   );

   ggw_ram #(.WIDTH(CellAddrW), .DEPTH(Cells)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // Squared distance below two means same cell or one orthogonal step away.
   assign cx    = {1'b0, cur_x_ff};
   assign cy    = {1'b0, cur_y_ff};
   assign gx    = {1'b0, cfg.goal_x};
   assign gy    = {1'b0, cfg.goal_y};
   assign x_eq  = (cx == gx);
   assign y_eq  = (cy == gy);
   assign x_adj = (cx + (CoordW + 1)'(1) == gx) || (gx + (CoordW + 1)'(1) == cx);
   assign y_adj = (cy + (CoordW + 1)'(1) == gy) || (gy + (CoordW + 1)'(1) == cy);
   assign near_calc = (x_eq && (y_eq || y_adj)) || (x_adj && y_eq);

   assign scan_nb  = nb_coord(cur_x_ff, cur_y_ff, scan_ff[1:0]);
   assign best_nb  = nb_coord(cur_x_ff, cur_y_ff, best_dir_ff);
   assign count_m1 = count_ff - CountW'(1);

   assign load_in_grid = ({1'b0, item_ff.cell_x} < SideLim) &&
                         ({1'b0, item_ff.cell_y} < SideLim);

   // A neighbour qualifies if inside, unmarked, not a wall and strictly cheaper.
   assign cand_ok = pend_ok_ff && !cell_rdata[MemW-1] &&
                    (cell_rdata[CostW-1:0] <= cfg.wall_limit) &&
                    (cell_rdata[CostW-1:0] < best_cost_ff);

   always_comb begin
      state_in      = state_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      item_in       = item_ff;
      near_in       = near_ff;
      scan_in       = scan_ff;
      pend_ok_in    = pend_ok_ff;
      pend_dir_in   = pend_dir_ff;
      best_found_in = best_found_ff;
      best_dir_in   = best_dir_ff;
      best_cost_in  = best_cost_ff;
      status_in     = status_ff;

      cell_we    = 1'b0;
      cell_waddr = {item_ff.cell_x, item_ff.cell_y};
      cell_wdata = {cell_rdata[MemW-1], item_ff.cell_cost};
      cell_raddr = {item_ff.cell_x, item_ff.cell_y};
      stk_we     = 1'b0;
      stk_waddr  = count_ff[CellAddrW-1:0];
      stk_wdata  = {best_nb.x, best_nb.y};
      stk_raddr  = count_m1[CellAddrW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_ff;
            cell_wdata = '0;
            clr_in     = clr_ff + CellAddrW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (in_valid) begin
               item_in       = in_item;
               near_in       = (in_item.kind == KindStep) && near_calc;
               scan_in       = '0;
               best_found_in = 1'b0;
               best_cost_in  = Uncarved;
               state_in      = (in_item.kind == KindStep) ? S_SCAN : S_LOAD_RD;
            end
         end
         S_LOAD_RD: begin
            state_in = S_LOAD_WR;
         end
         S_LOAD_WR: begin
            // Keep the visited mark, replace the cost.
            cell_we   = load_in_grid;
            status_in = ST_LOADED;
            state_in  = S_DONE;
         end
         S_SCAN: begin
            // Read of direction k goes out while direction k-1 is judged.
            cell_raddr  = {scan_nb.x, scan_nb.y};
            pend_ok_in  = scan_nb.ok;
            pend_dir_in = scan_ff[1:0];
            if ((scan_ff != '0) && cand_ok) begin
               best_found_in = 1'b1;
               best_dir_in   = pend_dir_ff;
               best_cost_in  = cell_rdata[CostW-1:0];
            end
            scan_in = scan_ff + 3'd1;
            if (scan_ff[2]) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (best_found_ff) begin
               cur_x_in   = best_nb.x;
               cur_y_in   = best_nb.y;
               cell_we    = 1'b1;
               cell_waddr = {best_nb.x, best_nb.y};
               cell_wdata = {1'b1, best_cost_ff};
               stk_we     = !count_ff[CountW-1];
               count_in   = count_ff + CountW'(!count_ff[CountW-1]);
               status_in  = ST_MOVED;
               state_in   = S_DONE;
            end else if (count_ff != '0) begin
               count_in = count_m1;
               state_in = S_POP;
            end else begin
               status_in = ST_NOPATH;
               state_in  = S_DONE;
            end
         end
         S_POP: begin
            cur_x_in  = stk_rdata[CellAddrW-1:CoordW];
            cur_y_in  = stk_rdata[CoordW-1:0];
            status_in = ST_BACK;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (pos_set.set_x) begin
         cur_x_in = pos_set.x;
      end
      if (pos_set.set_y) begin
         cur_y_in = pos_set.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cur_x_ff <= StartReset;
         cur_y_ff <= StartReset;
         count_ff <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      near_ff       <= near_in;
      scan_ff       <= scan_in;
      pend_ok_ff    <= pend_ok_in;
      pend_dir_ff   <= pend_dir_in;
      best_found_ff <= best_found_in;
      best_dir_ff   <= best_dir_in;
      best_cost_ff  <= best_cost_in;
      status_ff     <= status_in;
   end

   assign in_ready      = (state_ff == S_IDLE);
   assign res_valid     = (state_ff == S_DONE);
   assign res.pos_x     = cur_x_ff;
   assign res.pos_y     = cur_y_ff;
   assign res.status    = status_ff;
   assign res.goal_near = near_ff;

`ifndef SYNTHESIS
   ap_push_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && best_found_ff && !count_ff[CountW-1])
      |=> (count_ff == $past(count_ff) + CountW'(1)))
      else $error("stack count did not grow on a move");

   // A load rewrites an existing mark; only a move sets a new one.
   ap_mark_on_move: assert property (@(posedge clock) disable iff (reset)
      (cell_we && cell_wdata[MemW-1])
      |-> (state_ff == S_DECIDE || (state_ff == S_LOAD_WR && cell_rdata[MemW-1])))
      else $error("visited mark written outside a move");

   ap_pop_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP)
      |-> ($past(state_ff) == S_DECIDE && $past(count_ff) != '0))
      else $error("pop without a non-empty stack");

   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(Cells))
      else $error("stack count beyond depth");
`endif

endmodule

`default_nettype wire

/* hw/rtl/greedy_grid_walker.sv */
// ----------------------------------------------------------------------------
// greedy_grid_walker: greedy depth-first walk over a loaded cost grid
// Usage: req_ words with tuser 0 load one cell cost; tuser 1 takes one walk
// step. Every request word gives exactly one rsp_ word with the position
// after the item, a status code and the goal-near flag.
// Configuration (start, goal, wall limit) is written on the csr_ port while
// no request is in flight; writing a start coordinate also moves the position.
// After reset the visited marks are swept clear, one cell per cycle, over all
// 4096 cells; req_tready stays low until the sweep ends.
// Sequence: a load reads the cell and then writes it back; a step reads the
// four neighbours one after another through the single read port of the cell
// memory, then decides, plus a stack read when it backtracks. A new request
// is taken only once the result of the last one has gone to the output
// register, which drives rsp_tvalid.
// One result may wait in the output register while the next request is
// taken; if rsp_tready stays low the block holds the following result and
// stops accepting until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_grid_walker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: cell_x [5:0], cell_y [11:6], cell_cost [25:12], zero [31:26]
   input  wire logic [31:0]                     req_tdata,
   // tuser: kind [0]
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: pos_x [5:0], pos_y [11:6], goal_near [12], zero [15:13]
   output logic [15:0]                          rsp_tdata,
   // tuser: status [1:0]
   output logic [1:0]                           rsp_tuser,
   input  wire logic                            csr_we,
   input  wire logic [ggw_pkg::CsrIndexW-1:0]   csr_index,
   input  wire logic [ggw_pkg::CostW-1:0]       csr_wdata
);

   import ggw_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   pos_set_type pos_set;
   item_type    in_item;
   result_type  res;
   result_type  rsp_res_ff;
   logic        rsp_valid_ff;
   logic        res_valid;
   logic        res_ready;

   always_comb begin
      cfg_in      = cfg_ff;
      pos_set.set_x = 1'b0;
      pos_set.set_y = 1'b0;
      pos_set.x   = csr_wdata[CoordW-1:0];
      pos_set.y   = csr_wdata[CoordW-1:0];
      if (csr_we) begin
         unique case (csr_index)
            REG_START_X: begin
               cfg_in.start_x = csr_wdata[CoordW-1:0];
               pos_set.set_x  = 1'b1;
            end
            REG_START_Y: begin
               cfg_in.start_y = csr_wdata[CoordW-1:0];
               pos_set.set_y  = 1'b1;
            end
            REG_GOAL_X:     cfg_in.goal_x     = csr_wdata[CoordW-1:0];
            REG_GOAL_Y:     cfg_in.goal_y     = csr_wdata[CoordW-1:0];
            REG_WALL_LIMIT: cfg_in.wall_limit = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_x    <= StartReset;
         cfg_ff.start_y    <= StartReset;
         cfg_ff.goal_x     <= GoalReset;
         cfg_ff.goal_y     <= GoalReset;
         cfg_ff.wall_limit <= WallLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign in_item.kind      = req_tuser;
   assign in_item.cell_x    = req_tdata[CoordW-1:0];
   assign in_item.cell_y    = req_tdata[2*CoordW-1:CoordW];
   assign in_item.cell_cost = req_tdata[2*CoordW+CostW-1:2*CoordW];

   ggw_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pos_set   (pos_set),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (in_item),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // Output register: the engine may finish only when the slot is free.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_res_ff.goal_near, rsp_res_ff.pos_y, rsp_res_ff.pos_x};
   assign rsp_tuser  = rsp_res_ff.status;

endmodule

`default_nettype wire

/* tb/tb_greedy_grid_walker.sv */
// ----------------------------------------------------------------------------
// tb_greedy_grid_walker: self-checking bench for the greedy grid walker
// A short table of hand-worked loads and steps in one grid corner comes first.
// Random walks over small loaded patches of the grid follow. Every cell that
// a step reads as a neighbour is loaded before that step. A predictor in the
// bench tracks costs, visited marks, the path stack and the position. Each
// result word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_greedy_grid_walker;
   import ggw_pkg::*;

   localparam int ItemsTotal = 1100;

   typedef enum logic [1:0] {DO_CSR, DO_LOAD, DO_STEP} plan_act_type;

   typedef struct packed {
      plan_act_type      act;
      reg_index_type     idx;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [CostW-1:0]  val;
      logic              typed;
      result_type        want;
   } plan_row_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;   // cell_x, cell_y, cell_cost, zero pad
   logic                 req_tuser  = 1'b0; // kind
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;         // pos_x, pos_y, goal_near, zero pad
   logic [1:0]           rsp_tuser;         // status
   logic                 csr_we     = 1'b0;
   logic [CsrIndexW-1:0] csr_index  = '0;
   logic [CostW-1:0]     csr_wdata  = '0;

   // Predicted walker state.
   logic [CoordW-1:0]    at_x     = StartReset;
   logic [CoordW-1:0]    at_y     = StartReset;
   logic [CoordW-1:0]    goal_x   = GoalReset;
   logic [CoordW-1:0]    goal_y   = GoalReset;
   logic [CostW-1:0]     wall_lim = WallLimitReset;
   logic [CostW-1:0]     cost_map [Cells];
   bit                   cost_known [Cells];
   bit                   trodden [Cells];
   logic [CellAddrW-1:0] trail [$];

   result_type           positions_due [$];
   status_type           last_status;
   int                   words_sent = 0;
   int                   faults     = 0;
   int                   hold_cycles = 0;
   bit                   hold_done   = 1'b0;

   // A stretch of the run in which neither side idles.
   wire calm = (words_sent >= 500) && (words_sent < 700);

   greedy_grid_walker DUT (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_we, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   // Neighbour d of the current position (x+1, y+1, x-1, y-1); true if inside.
   function automatic bit beside(input int d, output int nx, output int ny);
      nx = int'(at_x) + int'(d == 0) - int'(d == 2);
      ny = int'(at_y) + int'(d == 1) - int'(d == 3);
      return nx >= 0 && ny >= 0 && nx < Side && ny < Side;
   endfunction

   function automatic result_type advance_walker(input logic kind,
                                                 input logic [CoordW-1:0] lx, ly,
                                                 input logic [CostW-1:0] lcost);
      result_type r;
      int d, nx, ny, best, best_cost, ddx, ddy;
      logic [CellAddrW-1:0] spot;
      r = '0;
      r.status = ST_LOADED;
      if (kind == KindLoad) begin
         cost_map[{lx, ly}] = lcost;
         cost_known[{lx, ly}] = 1'b1;
      end else begin
         ddx = int'(at_x) - int'(goal_x);
         ddy = int'(at_y) - int'(goal_y);
         r.goal_near = (ddx * ddx + ddy * ddy) < 2;
         best = -1;
         best_cost = int'(Uncarved);
         for (d = 0; d < 4; d++) begin
            if (beside(d, nx, ny)) begin
               spot = {CoordW'(nx), CoordW'(ny)};
               // Strict compare: the first direction tried keeps a tie.
               if (!trodden[spot] && cost_map[spot] <= wall_lim &&
                   int'(cost_map[spot]) < best_cost) begin
                  best = d;
                  best_cost = int'(cost_map[spot]);
               end
            end
         end
         if (best >= 0) begin
            void'(beside(best, nx, ny));
            at_x = CoordW'(nx);
            at_y = CoordW'(ny);
            trail.insert(trail.size(), {at_x, at_y});
            trodden[{at_x, at_y}] = 1'b1;
            r.status = ST_MOVED;
         end else if (trail.size() > 0) begin
            spot = trail[$];
            trail.delete(trail.size() - 1);
            {at_x, at_y} = spot;
            r.status = ST_BACK;
         end else
            r.status = ST_NOPATH;
      end
      r.pos_x = at_x;
      r.pos_y = at_y;
      return r;
   endfunction

   function automatic logic [CostW-1:0] pick_cost();
      case ($urandom_range(7))
         0: return '0;
         1: return Uncarved;
         2: return (wall_lim < Uncarved) ? wall_lim + 1'b1 : wall_lim;
         3: return wall_lim;
         4: return CostW'($urandom_range(Uncarved));
         5: return CostW'($urandom_range(3));
         default: return CostW'($urandom_range(wall_lim));
      endcase
   endfunction

   function automatic plan_row_type csr_row(input reg_index_type idx, input int val);
      plan_row_type r;
      r = '0;
      r.act = DO_CSR;
      r.idx = idx;
      r.val = CostW'(val);
      return r;
   endfunction

   function automatic plan_row_type load_row(input int x, input int y, input int val);
      plan_row_type r;
      r = '0;
      r.act = DO_LOAD;
      r.x = CoordW'(x);
      r.y = CoordW'(y);
      r.val = CostW'(val);
      return r;
   endfunction

   function automatic plan_row_type step_row();
      plan_row_type r;
      r = '0;
      r.act = DO_STEP;
      return r;
   endfunction

   function automatic plan_row_type expecting(input plan_row_type r, input int px,
                                              input int py, input status_type st,
                                              input bit near);
      r.typed = 1'b1;
      r.want.pos_x = CoordW'(px);
      r.want.pos_y = CoordW'(py);
      r.want.status = st;
      r.want.goal_near = near;
      return r;
   endfunction

   // Offers one request word and records the prediction once it is taken.
   task automatic send_word(input logic kind, input logic [CoordW-1:0] x, y,
                            input logic [CostW-1:0] cost, input bit typed,
                            input result_type want);
      result_type guess;
      csr_we <= 1'b0;
      while (!calm && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, cost, y, x};
      do @(posedge clock); while (!req_tready);
      guess = advance_walker(kind, x, y, cost);
      last_status = guess.status;
      positions_due.insert(positions_due.size(), typed ? want : guess);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CostW-1:0] val);
      req_tvalid <= 1'b0;
      csr_we     <= 1'b1;
      csr_index  <= idx;
      csr_wdata  <= val;
      @(posedge clock);
      case (idx)
         REG_START_X: at_x = val[CoordW-1:0];
         REG_START_Y: at_y = val[CoordW-1:0];
         REG_GOAL_X:  goal_x = val[CoordW-1:0];
         REG_GOAL_Y:  goal_y = val[CoordW-1:0];
         default:     wall_lim = val;
      endcase
      @(negedge clock);
   endtask

   // Stops offering and waits until every predicted word has come back.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      do @(negedge clock); while (positions_due.size() != 0);
      @(negedge clock);
   endtask

   initial begin : stimulus
      plan_row_type plan [$];
      plan_row_type r;
      logic [CoordW-1:0] sx, sy;
      logic [CostW-1:0] wl;
      int ep, w, h, x0, y0, n, i, j, k, d, nx, ny;

      // Hand-worked walk in the corner at the origin, goal one cell along x from it.
      plan = {plan, csr_row(REG_START_X, 0)};
      plan = {plan, csr_row(REG_START_Y, 0)};
      plan = {plan, csr_row(REG_GOAL_X, 1)};
      plan = {plan, csr_row(REG_GOAL_Y, 0)};
      plan = {plan, expecting(load_row(63, 63, 8191), 0, 0, ST_LOADED, 0)};
      plan = {plan, expecting(load_row(63, 0, 10000), 0, 0, ST_LOADED, 0)};
      plan = {plan, expecting(load_row(0, 0, 0), 0, 0, ST_LOADED, 0)};
      plan = {plan, load_row(1, 0, 7)};
      plan = {plan, load_row(0, 1, 7)};
      plan = {plan, load_row(1, 1, 10000)};
      plan = {plan, load_row(2, 0, 10000)};
      plan = {plan, load_row(0, 2, 1001)};
      plan = {plan, expecting(step_row(), 1, 0, ST_MOVED, 1)};  // tie goes to x+1
      plan = {plan, expecting(step_row(), 0, 0, ST_MOVED, 1)};  // start cell re-entered
      plan = {plan, expecting(step_row(), 0, 1, ST_MOVED, 1)};
      plan = {plan, expecting(step_row(), 0, 1, ST_BACK, 0)};   // top is the cell itself
      plan = {plan, expecting(step_row(), 0, 0, ST_BACK, 0)};
      plan = {plan, expecting(step_row(), 1, 0, ST_BACK, 1)};
      plan = {plan, expecting(step_row(), 1, 0, ST_NOPATH, 1)};
      plan = {plan, csr_row(REG_WALL_LIMIT, 10000)};
      plan = {plan, expecting(step_row(), 1, 0, ST_NOPATH, 1)}; // uncarved stays a wall
      plan = {plan, expecting(load_row(1, 1, 9999), 1, 0, ST_LOADED, 0)};
      plan = {plan, expecting(step_row(), 1, 1, ST_MOVED, 1)};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[p]) begin
         r = plan[p];
         case (r.act)
            DO_CSR: begin
               quiesce();
               write_reg(r.idx, r.val);
            end
            DO_LOAD: send_word(KindLoad, r.x, r.y, r.val, r.typed, r.want);
            default: send_word(KindStep, CoordW'($urandom), CoordW'($urandom),
                               CostW'($urandom_range(Uncarved)), r.typed, r.want);
         endcase
      end

      ep = 0;
      while (words_sent < ItemsTotal) begin
         quiesce();
         if (ep == 0) begin
            sx = 63;
            sy = 63;
            wl = '0;
         end else if (ep == 1) begin
            sx = 0;
            sy = 63;
            wl = Uncarved;
         end else begin
            sx = ($urandom_range(7) == 0) ? CoordW'(63 * $urandom_range(1))
                                          : CoordW'($urandom_range(63));
            sy = ($urandom_range(7) == 0) ? CoordW'(63 * $urandom_range(1))
                                          : CoordW'($urandom_range(63));
            case ($urandom_range(7))
               0: wl = '0;
               1: wl = Uncarved;
               default: wl = CostW'($urandom_range(Uncarved));
            endcase
         end
         if (ep < 2 || $urandom_range(3) != 0) begin
            write_reg(REG_START_X, sx);
            write_reg(REG_START_Y, sy);
         end
         if (ep < 2 || $urandom_range(3) != 0) begin
            // In the first patch, and half the time after it, the goal lands on or beside the walk's position.
            if (ep == 0 || $urandom_range(1)) begin
               write_reg(REG_GOAL_X, CostW'(CoordW'(at_x + $urandom_range(2) - 1)));
               write_reg(REG_GOAL_Y, CostW'(CoordW'(at_y + $urandom_range(2) - 1)));
            end else begin
               write_reg(REG_GOAL_X, CostW'(ep == 1 ? 63 : $urandom_range(63)));
               write_reg(REG_GOAL_Y, CostW'(ep == 1 ? 0 : $urandom_range(63)));
            end
         end
         if (ep < 2 || $urandom_range(3) != 0)
            write_reg(REG_WALL_LIMIT, wl);

         // Load a small patch around the position, then walk it.
         w = $urandom_range(5, 1);
         h = $urandom_range(5, 1);
         x0 = int'(at_x) - int'($urandom_range(w - 1, 0));
         y0 = int'(at_y) - int'($urandom_range(h - 1, 0));
         if (x0 < 0) x0 = 0;
         if (x0 > Side - w) x0 = Side - w;
         if (y0 < 0) y0 = 0;
         if (y0 > Side - h) y0 = Side - h;
         for (i = x0; i < x0 + w; i++)
            for (j = y0; j < y0 + h; j++)
               send_word(KindLoad, CoordW'(i), CoordW'(j), pick_cost(), 1'b0, '0);

         n = $urandom_range(3 * w * h + 4, 4);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(15) == 0)
               send_word(KindLoad, CoordW'($urandom), CoordW'($urandom), pick_cost(),
                         1'b0, '0);
            // A step reads every neighbour inside the grid, so none may be unloaded.
            for (d = 0; d < 4; d++)
               if (beside(d, nx, ny) && !cost_known[{CoordW'(nx), CoordW'(ny)}])
                  send_word(KindLoad, CoordW'(nx), CoordW'(ny),
                            ($urandom_range(3) == 0) ? pick_cost() : Uncarved, 1'b0, '0);
            send_word(KindStep, CoordW'($urandom), CoordW'($urandom),
                      CostW'($urandom_range(Uncarved)), 1'b0, '0);
            if (last_status == ST_NOPATH && $urandom_range(1))
               break;
         end
         ep++;
      end

      quiesce();
      repeat (20) @(posedge clock);
      if (faults == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Result side: random back-pressure plus one long hold-off while requests
   // keep coming, so that the block fills up and stops taking words.
   always @(negedge clock) begin
      if (!hold_done && words_sent >= 350) begin
         hold_cycles = 400;
         hold_done = 1'b1;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= calm || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin : check_results
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pos_x = rsp_tdata[5:0];
         got.pos_y = rsp_tdata[11:6];
         got.goal_near = rsp_tdata[12];
         got.status = status_type'(rsp_tuser);
         if (positions_due.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected result word: pos %0d,%0d status %0d near %0d",
                        got.pos_x, got.pos_y, got.status, got.goal_near);
         end else begin
            want = positions_due.pop_front();
            if (got !== want) begin
               faults++;
               if (faults <= 10)
                  $display("result mismatch: expected pos %0d,%0d status %0d near %0d, %s",
                           want.pos_x, want.pos_y, want.status, want.goal_near,
                           $sformatf("got pos %0d,%0d status %0d near %0d",
                                     got.pos_x, got.pos_y, got.status, got.goal_near));
            end
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
